FILE: src/uart_pkg.sv
// uart_pkg: item types, receiver phase codes and fixed constants for the
// 8N1 transceiver. No dependencies.
`default_nettype none

package uart_pkg;

  localparam logic [15:0] TicksPerBitReset = 16'd104;
  localparam logic [15:0] TicksPerBitMin   = 16'd2;

  typedef enum logic [1:0] {
    RX_IDLE = 2'd0,
    RX_DATA = 2'd1,
    RX_STOP = 2'd2
  } rx_phase_e;

  typedef struct packed {
    logic       rx_level;
    logic       send_request;
    logic [7:0] send_byte;
  } uart_in_t;

  typedef struct packed {
    logic       tx_level;
    logic       tx_busy;
    logic       rx_done;
    logic [7:0] rx_data;
    logic       rx_frame_error;
  } uart_out_t;

endpackage

`default_nettype wire

FILE: src/uart_8n1_transceiver.sv
// uart_8n1_transceiver: tick-driven 8N1 serial transmitter and receiver.
// Depends on uart_pkg for item types and receiver phase codes.
//
// Usage: every input item is one tick of the bit-timing base. It carries the
// sampled receive line level and an optional transmit request with its byte.
// Each accepted item yields exactly one output item: the transmit line level
// and busy flag for that tick, plus a received byte with rx_done and
// rx_frame_error on the tick the stop bit is sampled.
// The output item for a tick is registered: in the output register, or in the
// skid register while the sink stalls. Throughput: one item per cycle while
// in_ready_o is high; all per-tick work is one pass of short logic between
// the state registers and the output register. A two-entry output stage
// (output register plus skid register) lets the block take one more item
// while the sink stalls; in_ready_o drops only once both entries hold an item.
// Configuration: cfg_data_i sets ticks_per_bit (values below 2 act as 2);
// cfg_ready_o is always high. A new period applies at once to the bit being
// sent, and to the receiver from its next count reload.
// Reset: line idle high, transmitter and receiver idle, ticks_per_bit = 104,
// no output item pending.
`default_nettype none

module uart_8n1_transceiver
  import uart_pkg::*;
#(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire uart_in_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output uart_out_t      out_item_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  localparam int unsigned FrameBits = DATA_BITS + 2;

  logic [15:0]          ticks_per_bit_q;
  logic [FrameBits-1:0] tx_shift_q, tx_shift_d;
  logic [3:0]           tx_bits_left_q, tx_bits_left_d;
  logic [15:0]          tx_tick_count_q, tx_tick_count_d;
  rx_phase_e            rx_phase_q, rx_phase_d;
  logic [3:0]           rx_bit_index_q, rx_bit_index_d;
  logic [16:0]          rx_tick_count_q, rx_tick_count_d;
  logic [7:0]           rx_shift_q, rx_shift_d;

  uart_out_t out_q, skid_q, result;
  logic      out_valid_q, skid_valid_q;

  logic                 accept;
  logic [15:0]          period;
  logic                 tx_start;
  logic [FrameBits-1:0] tx_shift_a;
  logic [3:0]           tx_bits_a;
  logic [15:0]          tx_cnt_a, tx_cnt_inc;
  logic [3:0]           rx_idx_inc;
  logic                 res_tx_level, res_tx_busy, res_rx_done, res_rx_ferr;
  logic [7:0]           res_rx_data;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign period = (ticks_per_bit_q < TicksPerBitMin) ? TicksPerBitMin : ticks_per_bit_q;

  // transmitter
  assign tx_start   = (tx_bits_left_q == 4'd0) && in_item_i.send_request;
  assign tx_shift_a = tx_start ? {1'b1, DATA_BITS'(in_item_i.send_byte), 1'b0} : tx_shift_q;
  assign tx_bits_a  = tx_start ? 4'(FrameBits) : tx_bits_left_q;
  assign tx_cnt_a   = tx_start ? 16'd0 : tx_tick_count_q;
  assign tx_cnt_inc = tx_cnt_a + 16'd1;

  always_comb begin
    tx_shift_d      = tx_shift_a;
    tx_bits_left_d  = tx_bits_a;
    tx_tick_count_d = tx_cnt_a;
    res_tx_level    = 1'b1;
    res_tx_busy     = 1'b0;
    if (tx_bits_a != 4'd0) begin
      res_tx_level = tx_shift_a[0];
      res_tx_busy  = 1'b1;
      if (tx_cnt_inc >= period) begin
        tx_tick_count_d = 16'd0;
        tx_shift_d      = {1'b1, tx_shift_a[FrameBits-1:1]};
        tx_bits_left_d  = tx_bits_a - 4'd1;
      end else begin
        tx_tick_count_d = tx_cnt_inc;
      end
    end
  end

  // receiver
  assign rx_idx_inc = rx_bit_index_q + 4'd1;

  always_comb begin
    rx_phase_d      = rx_phase_q;
    rx_bit_index_d  = rx_bit_index_q;
    rx_tick_count_d = rx_tick_count_q;
    rx_shift_d      = rx_shift_q;
    res_rx_done     = 1'b0;
    res_rx_data     = 8'd0;
    res_rx_ferr     = 1'b0;
    unique case (rx_phase_q)
      RX_DATA: begin
        if (rx_tick_count_q > 17'd1) begin
          rx_tick_count_d = rx_tick_count_q - 17'd1;
        end else begin
          if (!rx_bit_index_q[3] && in_item_i.rx_level) begin
            rx_shift_d[rx_bit_index_q[2:0]] = 1'b1;
          end
          rx_bit_index_d  = rx_idx_inc;
          rx_tick_count_d = 17'(period);
          if (rx_idx_inc >= 4'(DATA_BITS)) begin
            rx_phase_d = RX_STOP;
          end
        end
      end
      RX_STOP: begin
        if (rx_tick_count_q > 17'd1) begin
          rx_tick_count_d = rx_tick_count_q - 17'd1;
        end else begin
          res_rx_done = 1'b1;
          res_rx_data = rx_shift_q;
          res_rx_ferr = !in_item_i.rx_level;
          rx_phase_d  = RX_IDLE;
        end
      end
      default: begin
        rx_phase_d = RX_IDLE;
        if (!in_item_i.rx_level) begin
          rx_phase_d      = RX_DATA;
          rx_bit_index_d  = 4'd0;
          rx_shift_d      = 8'd0;
          rx_tick_count_d = 17'(period) + 17'(period >> 1);
        end
      end
    endcase
  end

  assign result = '{
    tx_level:       res_tx_level,
    tx_busy:        res_tx_busy,
    rx_done:        res_rx_done,
    rx_data:        res_rx_data,
    rx_frame_error: res_rx_ferr
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_per_bit_q <= TicksPerBitReset;
      tx_shift_q      <= '1;
      tx_bits_left_q  <= 4'd0;
      tx_tick_count_q <= 16'd0;
      rx_phase_q      <= RX_IDLE;
      rx_bit_index_q  <= 4'd0;
      rx_tick_count_q <= 17'd0;
      rx_shift_q      <= 8'd0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        ticks_per_bit_q <= cfg_data_i;
      end
      if (accept) begin
        tx_shift_q      <= tx_shift_d;
        tx_bits_left_q  <= tx_bits_left_d;
        tx_tick_count_q <= tx_tick_count_d;
        rx_phase_q      <= rx_phase_d;
        rx_bit_index_q  <= rx_bit_index_d;
        rx_tick_count_q <= rx_tick_count_d;
        rx_shift_q      <= rx_shift_d;
      end
    end
  end

  // output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (accept) begin
      if (!out_valid_q || out_ready_i) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_ready_i) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_valid_q || out_ready_i) begin
        out_q <= result;
      end else begin
        skid_q <= result;
      end
    end else if (out_ready_i && skid_valid_q) begin
      out_q <= skid_q;
    end
  end

endmodule

`default_nettype wire

FILE: src/uart_chk.sv
// uart_chk: port-level checks for uart_8n1_transceiver, bound into that module.
// Depends on uart_pkg for item types.
`default_nettype none

module uart_chk
  import uart_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_ready_o,
  input wire logic      out_valid_o,
  input wire logic      out_ready_i,
  input wire uart_out_t out_item_o
);

  // idle transmitter holds the line high
  a_tx_idle_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.tx_busy) |-> out_item_o.tx_level)
    else $error("tx line low while transmitter idle");

  // receive fields are zero outside a completed frame
  a_rx_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.rx_done) |->
      (out_item_o.rx_data == 8'd0 && !out_item_o.rx_frame_error))
    else $error("rx fields set without rx_done");

  // input backpressure only while an item is waiting at the output
  a_ready_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("in_ready low with no output item pending");

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("output item changed while stalled");

endmodule

bind uart_8n1_transceiver uart_chk u_uart_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for uart_8n1_transceiver, one line tick per item,
// predicted by an in-bench UART model. Depends on uart_pkg and the DUT source.
module tb;
  import uart_pkg::*;

  localparam int DataBits   = 8;
  localparam int HoldAt     = 300;
  localparam int HoldCycles = 120;
  localparam int QuietLimit = 2000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  uart_in_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  uart_out_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [15:0] cfg_data_i = '0;

  uart_8n1_transceiver #(
    .DATA_BITS(DataBits)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // model state
  logic [15:0] tpb;
  logic [9:0]  tx_sr;
  logic [3:0]  tx_left;
  logic [15:0] tx_cnt;
  rx_phase_e   rx_ph;
  logic [3:0]  rx_idx;
  logic [16:0] rx_cnt;
  logic [7:0]  rx_sr;

  uart_in_t  tick_q[$];
  uart_out_t line_out_q[$];

  bit gaps_on = 1'b0;
  int src_wait, sink_wait, quiet_cycles;
  int n_pushed, n_acc, n_out, n_bad, n_rand, n_settings;
  int n_tx_starts, n_frames, n_ferr;

  function automatic int draw_gap();
    return gaps_on ? $urandom_range(0, 18) : 0;
  endfunction

  function automatic uart_out_t step_uart(input uart_in_t t);
    logic [16:0] p;
    uart_out_t   r;
    p = (tpb < TicksPerBitMin) ? {1'b0, TicksPerBitMin} : {1'b0, tpb};
    r = '0;

    if (tx_left == 4'd0 && t.send_request) begin
      tx_sr   = {1'b1, t.send_byte, 1'b0};
      tx_left = 4'(DataBits + 2);
      tx_cnt  = '0;
      n_tx_starts++;
    end
    if (tx_left != 4'd0) begin
      r.tx_level = tx_sr[0];
      r.tx_busy  = 1'b1;
      tx_cnt = tx_cnt + 16'd1;
      if ({1'b0, tx_cnt} >= p) begin
        tx_cnt  = '0;
        tx_sr   = {1'b1, tx_sr[9:1]};
        tx_left = tx_left - 4'd1;
      end
    end else begin
      r.tx_level = 1'b1;
    end

    if (rx_ph == RX_DATA || rx_ph == RX_STOP) begin
      if (rx_cnt > 17'd1) begin
        rx_cnt = rx_cnt - 17'd1;
      end else if (rx_ph == RX_DATA) begin
        if (rx_idx < 4'd8 && t.rx_level) rx_sr[rx_idx[2:0]] = 1'b1;
        rx_idx = rx_idx + 4'd1;
        rx_cnt = p;
        if (rx_idx >= DataBits) rx_ph = RX_STOP;
      end else begin
        r.rx_done        = 1'b1;
        r.rx_data        = rx_sr;
        r.rx_frame_error = ~t.rx_level;
        rx_ph = RX_IDLE;
        n_frames++;
        if (!t.rx_level) n_ferr++;
      end
    end else begin
      rx_ph = RX_IDLE;
      if (!t.rx_level) begin
        rx_ph  = RX_DATA;
        rx_idx = '0;
        rx_sr  = '0;
        rx_cnt = p + (p >> 1);
      end
    end
    return r;
  endfunction

  // sender
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      src_wait   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        line_out_q.push_back(step_uart(in_item_i));
        n_acc++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (src_wait != 0) begin
          in_valid_i <= 1'b0;
          src_wait   <= src_wait - 1;
        end else if (tick_q.size() != 0) begin
          in_item_i  <= tick_q.pop_front();
          in_valid_i <= 1'b1;
          src_wait   <= draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver side: check each result item, random stalls, one long hold
  always @(posedge clk_i) begin : sink_side
    int        w;
    uart_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      sink_wait   <= 0;
    end else if (out_valid_o && out_ready_i) begin
      n_out++;
      if (line_out_q.size() == 0) begin
        if (n_bad < 10) $display("result item %0d arrived with none expected", n_out);
        n_bad++;
      end else begin
        want = line_out_q.pop_front();
        if (out_item_o.tx_level !== want.tx_level || out_item_o.tx_busy !== want.tx_busy ||
            out_item_o.rx_done !== want.rx_done || out_item_o.rx_data !== want.rx_data ||
            out_item_o.rx_frame_error !== want.rx_frame_error) begin
          if (n_bad < 10) begin
            $display("item %0d: exp tx=%b busy=%b done=%b data=%h ferr=%b",
                     n_out, want.tx_level, want.tx_busy, want.rx_done, want.rx_data,
                     want.rx_frame_error);
            $display("item %0d: got tx=%b busy=%b done=%b data=%h ferr=%b",
                     n_out, out_item_o.tx_level, out_item_o.tx_busy,
                     out_item_o.rx_done, out_item_o.rx_data, out_item_o.rx_frame_error);
          end
          n_bad++;
        end
      end
      w = (n_out == HoldAt) ? HoldCycles : draw_gap();
      if (w == 0) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b0;
        sink_wait   <= w;
      end
    end else if (!out_ready_i) begin
      if (sink_wait <= 1) out_ready_i <= 1'b1;
      sink_wait <= sink_wait - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("stalled for %0d cycles", QuietLimit);
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic push_item(input logic rx, input logic req, input logic [7:0] b);
    uart_in_t t;
    t.rx_level     = rx;
    t.send_request = req;
    t.send_byte    = b;
    tick_q.push_back(t);
    n_pushed++;
  endtask

  task automatic push_tick(input logic rx);
    push_item(rx, $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_frame(input int bp, input logic [7:0] b, input logic stop,
                            input int max_ticks);
    logic [9:0] frame_bits;
    int         n;
    frame_bits = {stop, b, 1'b0};
    n = 0;
    for (int i = 0; i < 10; i++) begin
      for (int k = 0; k < bp; k++) begin
        if (n < max_ticks) push_tick(frame_bits[i]);
        n++;
      end
    end
  endtask

  task automatic write_period(input logic [15:0] v);
    @(posedge clk_i);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tpb = v;
    n_settings++;
  endtask

  task automatic settle();
    while (n_acc != n_pushed || line_out_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic fill_random_phase(input int bp);
    int start, target;
    start  = n_pushed;
    target = $urandom_range(40, 160);
    while (n_pushed - start < target) begin
      case ($urandom_range(0, 9))
        6: push_frame(bp, 8'($urandom_range(0, 255)), 1'b0, 10 * bp);
        7: push_frame(($urandom_range(0, 1) != 0) ? bp + 1 : bp - 1,
                      8'($urandom_range(0, 255)), 1'b1, 10 * bp);
        8: begin
          repeat ($urandom_range(1, bp)) push_tick(1'b0);
          repeat ($urandom_range(bp, 3 * bp)) push_tick(1'b1);
        end
        9: repeat ($urandom_range(1, 3 * bp)) push_tick(1'b1);
        default: begin
          push_frame(bp, 8'($urandom_range(0, 255)), 1'b1, 10 * bp);
          repeat ($urandom_range(0, bp)) push_tick(1'b1);
        end
      endcase
    end
    // cut frame so the next period lands mid-frame
    if ($urandom_range(0, 2) == 0)
      push_frame(bp, 8'($urandom_range(0, 255)), 1'b1, $urandom_range(1, 10 * bp));
    n_rand += n_pushed - start;
  endtask

  initial begin
    logic [15:0] per;
    int          bp;
    bit          slow_done;
    tpb       = TicksPerBitReset;
    tx_sr     = '1;
    tx_left   = '0;
    tx_cnt    = '0;
    rx_ph     = RX_IDLE;
    rx_idx    = '0;
    rx_cnt    = '0;
    rx_sr     = '0;
    slow_done = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // zero period acts as 2; low stop bit, request while busy, line still
    // low after the stop sample, request right after busy drops
    write_period(16'd0);
    push_item(1'b0, 1'b1, 8'hFF);
    for (int i = 1; i <= 20; i++) push_item(1'b0, i == 4 || i == 20, (i == 4) ? 8'h55 : 8'h00);
    push_item(1'b1, 1'b0, 8'hAA);
    push_item(1'b1, 1'b1, 8'h55);
    settle();

    while (n_pushed < 720) begin
      case ($urandom_range(0, 7))
        0: per = 16'd1;
        1: per = 16'd2;
        2: per = 16'd3;
        3: per = 16'd4;
        4: per = 16'd5;
        5: per = 16'd7;
        6: per = 16'd11;
        default: per = 16'd24;
      endcase
      bp = (per < 2) ? 2 : int'(per);
      gaps_on = ($urandom_range(0, 3) != 0);
      write_period(per);
      fill_random_phase(bp);
      if (!slow_done && n_rand >= 300) begin
        // let the receiver go idle before the slowest period
        repeat (12 * bp + 4) push_item(1'b1, 1'b0, 8'h00);
      end
      settle();
      if (!slow_done && n_rand >= 300) begin
        write_period(16'hFFFF);
        push_item(1'b1, 1'b1, 8'h00);
        repeat (10) push_item(1'b1, 1'b0, 8'($urandom_range(0, 255)));
        settle();
        slow_done = 1'b1;
      end
    end

    gaps_on = 1'b0;
    repeat (8) @(posedge clk_i);
    n_bad += line_out_q.size();
    $display("Drove %0d ticks under %0d period settings, 0 and 65535 among them.",
             n_acc, n_settings);
    $display("Checked %0d outputs: %0d tx starts, %0d frames, %0d framing errors.",
             n_out, n_tx_starts, n_frames, n_ferr);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/uart_pkg.sv
src/uart_8n1_transceiver.sv
src/uart_chk.sv
tb/tb.sv
